// File: src/rtvcr_pkg.sv
package rtvcr_pkg;

  // Stream word layout of the input channel.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;
  localparam int SLOT_LSB   = 0;
  localparam int SLOT_W     = 5;
  localparam int TAZ_LSB    = 5;
  localparam int AZ_W       = 15;
  localparam int TRG_LSB    = 20;
  localparam int RG_W       = 16;
  localparam int CAZ_LSB    = 36;
  localparam int CRG_LSB    = 51;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_RENDER_ENABLE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_TRACKS      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AZ_GAP_GAIN        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AZ_CORRECTION_GAIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_GAP_GAIN     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY_GAIN     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_RANGE_SPAN     = 3'd6;

  localparam logic        RST_RENDER_ENABLE      = 1'b1;
  localparam logic [5:0]  RST_ACTIVE_TRACKS      = 6'd25;
  localparam logic [15:0] RST_AZ_GAP_GAIN        = 16'd512;
  localparam logic [15:0] RST_AZ_CORRECTION_GAIN = 16'd256;
  localparam logic [15:0] RST_RANGE_GAP_GAIN     = 16'd25600;
  localparam logic [15:0] RST_INTENSITY_GAIN     = 16'd256;
  localparam logic [15:0] RST_INV_RANGE_SPAN     = 16'd655;

  // A level of one in Q1.16.
  localparam logic [16:0] LEVEL_ONE = 17'h10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE_MUL,
    ST_CORR_MUL,
    ST_CORR_SUB,
    ST_CORR_CLAMP,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        render_enable;
    logic [5:0]  active_tracks;
    logic [15:0] az_gap_gain;
    logic [15:0] az_correction_gain;
    logic [15:0] range_gap_gain;
    logic [15:0] intensity_gain;
    logic [15:0] inv_range_span;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;
    logic cell_cap;
    logic ratio_mul;
    logic corr_mul;
    logic corr_sub;
    logic corr_clamp;
    logic track_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

  // One minus a scaled gap, clamped to 0..1: 65536 - (amount >> 8).
  function automatic logic [16:0] level_from(input logic [40:0] amount);
    logic [32:0] sub;
    logic [16:0] lvl;
    sub = amount[40:8];
    if (|sub[32:16]) begin
      lvl = '0;
    end else begin
      lvl = LEVEL_ONE - {1'b0, sub[15:0]};
    end
    return lvl;
  endfunction

endpackage

// File: src/rtvcr_ram.sv
module rtvcr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/rtvcr_regs.sv
module rtvcr_regs
  import rtvcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  // Register write decode; an unknown index changes nothing.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_RENDER_ENABLE:      cfg_nxt.render_enable      = cfg_data[0];
        REG_ACTIVE_TRACKS:      cfg_nxt.active_tracks      = cfg_data[5:0];
        REG_AZ_GAP_GAIN:        cfg_nxt.az_gap_gain        = cfg_data;
        REG_AZ_CORRECTION_GAIN: cfg_nxt.az_correction_gain = cfg_data;
        REG_RANGE_GAP_GAIN:     cfg_nxt.range_gap_gain     = cfg_data;
        REG_INTENSITY_GAIN:     cfg_nxt.intensity_gain     = cfg_data;
        REG_INV_RANGE_SPAN:     cfg_nxt.inv_range_span     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.render_enable      <= RST_RENDER_ENABLE;
      cfg_r.active_tracks      <= RST_ACTIVE_TRACKS;
      cfg_r.az_gap_gain        <= RST_AZ_GAP_GAIN;
      cfg_r.az_correction_gain <= RST_AZ_CORRECTION_GAIN;
      cfg_r.range_gap_gain     <= RST_RANGE_GAP_GAIN;
      cfg_r.intensity_gain     <= RST_INTENSITY_GAIN;
      cfg_r.inv_range_span     <= RST_INV_RANGE_SPAN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/rtvcr_ctrl.sv
module rtvcr_ctrl
  import rtvcr_pkg::*;
#(
  parameter int MAX_TRACKS = 32,
  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_command,
  output logic          out_tvalid,
  input  logic          out_tready,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] rd_addr,
  input  dp_status_t    status
);

  localparam int CW = $clog2(MAX_TRACKS + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [8:0]    active9;
  logic [8:0]    max9;
  logic [8:0]    clamp9;
  logic [CW-1:0] idx_inc;
  logic          in_fire;

  assign in_fire = in_tvalid && in_tready;
  assign idx_inc = idx_r + CW'(1);

  // Tracks summed for one cell: the register, limited to the table size.
  assign active9 = {3'b000, cfg.active_tracks};
  assign max9    = 9'(MAX_TRACKS);
  assign clamp9  = (active9 > max9) ? max9 : active9;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          if (in_command) begin
            cmd.cell_cap = 1'b1;
            count_nxt    = cfg.render_enable ? CW'(clamp9) : '0;
            state_nxt    = ST_RANGE_MUL;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_RANGE_MUL: begin
        cmd.ratio_mul = 1'b1;
        state_nxt     = ST_CORR_MUL;
      end
      ST_CORR_MUL: begin
        cmd.corr_mul = 1'b1;
        state_nxt    = ST_CORR_SUB;
      end
      ST_CORR_SUB: begin
        cmd.corr_sub = 1'b1;
        state_nxt    = ST_CORR_CLAMP;
      end
      ST_CORR_CLAMP: begin
        cmd.corr_clamp = 1'b1;
        idx_nxt        = '0;
        state_nxt      = (count_r == '0) ? ST_DRAIN : ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.track_rd = 1'b1;
        idx_nxt      = idx_inc;
        if (idx_inc == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign rd_addr    = idx_r[AW-1:0];
  assign out_tvalid = out_valid_r;

endmodule

// File: src/rtvcr_dp.sv
module rtvcr_dp
  import rtvcr_pkg::*;
#(
  parameter int MAX_TRACKS = 32,
  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  dp_cmd_t               cmd,
  input  logic [AW-1:0]         rd_addr,
  input  logic [IN_DATA_W-1:0]  in_data,
  output dp_status_t            status,
  output logic [OUT_DATA_W-1:0] cell_value
);

  localparam int ENTRY_W = AZ_W + RG_W;

  // Input word fields.
  logic [SLOT_W-1:0] slot;
  logic [AZ_W-1:0]   trk_az_in;
  logic [RG_W-1:0]   trk_rg_in;
  logic [AZ_W-1:0]   cell_az_in;
  logic [RG_W-1:0]   cell_rg_in;

  assign slot       = in_data[SLOT_LSB +: SLOT_W];
  assign trk_az_in  = in_data[TAZ_LSB +: AZ_W];
  assign trk_rg_in  = in_data[TRG_LSB +: RG_W];
  assign cell_az_in = in_data[CAZ_LSB +: AZ_W];
  assign cell_rg_in = in_data[CRG_LSB +: RG_W];

  // Track table write; slots beyond the table are dropped.
  logic [8:0]            slot9;
  logic                  wr_ok;
  logic [AW-1:0]         wr_addr;
  logic [ENTRY_W-1:0]    rd_data;
  logic [MAX_TRACKS-1:0] entry_vld_r;
  logic                  entry_vld_rd_r;

  assign slot9   = {4'b0000, slot};
  assign wr_ok   = cmd.load_wr && (slot9 < 9'(MAX_TRACKS));
  assign wr_addr = slot9[AW-1:0];

  rtvcr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TRACKS)
  ) u_track_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_addr),
    .wr_data ({trk_rg_in, trk_az_in}),
    .rd_en   (cmd.track_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
    end else if (wr_ok) begin
      entry_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.track_rd) begin
      entry_vld_rd_r <= entry_vld_r[rd_addr];
    end
  end

  // Stage valid flags, one per track in flight.
  logic [6:0] stage_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= '0;
    end else begin
      stage_vld_r <= {stage_vld_r[5:0], cmd.track_rd};
    end
  end

  assign status.pipe_busy = |stage_vld_r;

  // Per cell setup: range ratio, azimuth correction factor and intensity scale.
  logic [AZ_W-1:0]    cell_az_r;
  logic [RG_W-1:0]    cell_rg_r;
  logic [31:0]        ratio_prod;
  logic [23:0]        r16_r;
  logic [23:0]        k_nxt;
  logic [23:0]        k_r;
  logic signed [25:0] one_minus_r;
  logic signed [16:0] corr_gain_s;
  logic signed [42:0] corr_prod_nxt;
  logic signed [42:0] corr_prod_r;
  logic signed [42:0] f24_r;
  logic               f24_big;
  logic [38:0]        f24c_nxt;
  logic [38:0]        f24c_r;
  logic               az_full_r;

  assign ratio_prod    = cell_rg_r * cfg.inv_range_span;
  assign k_nxt         = {cfg.intensity_gain, 8'h00} - {8'h00, cfg.intensity_gain};
  assign one_minus_r   = 26'sd65536 - $signed({2'b00, r16_r});
  assign corr_gain_s   = $signed({1'b0, cfg.az_correction_gain});
  assign corr_prod_nxt = one_minus_r * corr_gain_s;
  // A factor above 2^38 already drives any nonzero gap to full saturation.
  assign f24_big       = !f24_r[42] && (|f24_r[41:38]);
  assign f24c_nxt      = f24_big ? 39'h40_0000_0000 : f24_r[38:0];

  always_ff @(posedge clk) begin
    if (cmd.cell_cap) begin
      cell_az_r <= cell_az_in;
      cell_rg_r <= cell_rg_in;
    end
    if (cmd.ratio_mul) begin
      r16_r <= ratio_prod[31:8];
      k_r   <= k_nxt;
    end
    if (cmd.corr_mul) begin
      corr_prod_r <= corr_prod_nxt;
    end
    if (cmd.corr_sub) begin
      f24_r <= 43'sd16777216 - corr_prod_r;
    end
    if (cmd.corr_clamp) begin
      az_full_r <= f24_r[42] || (f24_r == '0);
      f24c_r    <= f24c_nxt;
    end
  end

  // Track pipeline, stage two: absolute gaps.
  logic [AZ_W-1:0] trk_az;
  logic [RG_W-1:0] trk_rg;
  logic [AZ_W-1:0] gap_az_nxt, gap_az_r;
  logic [RG_W-1:0] gap_rg_nxt, gap_rg_r;

  assign trk_az     = entry_vld_rd_r ? rd_data[AZ_W-1:0] : '0;
  assign trk_rg     = entry_vld_rd_r ? rd_data[ENTRY_W-1:AZ_W] : '0;
  assign gap_az_nxt = (cell_az_r > trk_az) ? (cell_az_r - trk_az) : (trk_az - cell_az_r);
  assign gap_rg_nxt = (cell_rg_r > trk_rg) ? (cell_rg_r - trk_rg) : (trk_rg - cell_rg_r);

  // Stage three: corrected azimuth gap and normalized range gap.
  logic [53:0] az_prod_nxt, az_prod_r;
  logic [31:0] rg_prod;
  logic [23:0] n16_r;

  assign az_prod_nxt = gap_az_r * f24c_r;
  assign rg_prod     = gap_rg_r * cfg.inv_range_span;

  // Stage four: gap times slope; a gap of 2^24 or more saturates the level.
  logic [39:0] x_full;
  logic [24:0] x_sat;
  logic [40:0] amt_az_nxt, amt_az_r;
  logic [39:0] amt_rg_nxt, amt_rg_r;

  assign x_full     = az_prod_r[53:14];
  assign x_sat      = (|x_full[39:24]) ? 25'h100_0000 : {1'b0, x_full[23:0]};
  assign amt_az_nxt = x_sat * cfg.az_gap_gain;
  assign amt_rg_nxt = n16_r * cfg.range_gap_gain;

  // Stage five: levels.
  logic [16:0] lvl_az_nxt, lvl_az_r;
  logic [16:0] lvl_rg_nxt, lvl_rg_r;

  assign lvl_az_nxt = az_full_r ? LEVEL_ONE : level_from(amt_az_r);
  assign lvl_rg_nxt = level_from({1'b0, amt_rg_r});

  // Stage six and seven: level product, then intensity scale.
  logic [33:0] lvl_prod;
  logic [32:0] lvl_prod_r;
  logic [56:0] echo_prod;
  logic [16:0] add_r;

  assign lvl_prod  = lvl_az_r * lvl_rg_r;
  assign echo_prod = lvl_prod_r * k_r;

  always_ff @(posedge clk) begin
    gap_az_r   <= gap_az_nxt;
    gap_rg_r   <= gap_rg_nxt;
    az_prod_r  <= az_prod_nxt;
    n16_r      <= rg_prod[31:8];
    amt_az_r   <= amt_az_nxt;
    amt_rg_r   <= amt_rg_nxt;
    lvl_az_r   <= lvl_az_nxt;
    lvl_rg_r   <= lvl_rg_nxt;
    lvl_prod_r <= lvl_prod[32:0];
    add_r      <= echo_prod[56:40];
  end

  // Saturating accumulator and output word register.
  logic [7:0]  acc_r, acc_nxt;
  logic [17:0] acc_sum;
  logic [7:0]  cell_value_r;

  assign acc_sum = {10'b0, acc_r} + {1'b0, add_r};

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.cell_cap) begin
      acc_nxt = '0;
    end else if (stage_vld_r[6]) begin
      acc_nxt = (acc_sum > 18'd255) ? 8'd255 : acc_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.out_load) begin
      cell_value_r <= acc_r;
    end
  end

  assign cell_value = cell_value_r;

endmodule

// File: src/radar_track_video_cell_renderer.sv
// Radar track video cell renderer. A load word (tuser low) writes the azimuth
// and range of one track into the track table. A render word (tuser high)
// gives one cell's centre azimuth and range and returns one output word with
// the cell's video level: the saturated sum over the first active_tracks table
// entries (at most MAX_TRACKS, none while render_enable is low) of
// 255 * intensity * azimuth level * range level. A render word passes through
// four per cell setup steps, one table read per track through the single read
// port of the track memory, a drain of the track pipeline and a hand-over of
// the level to the output register. A finished word waits in the output
// register while the next input word is taken. Configuration is to be written
// only while idle; the block itself does not enforce this.
module radar_track_video_cell_renderer
  import rtvcr_pkg::*;
#(
  parameter int MAX_TRACKS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tdata, lowest bit up: track_slot, track_azimuth, track_range,
  // cell_azimuth, cell_range, zero fill.
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // tuser: command.
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: cell_value.
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  cfg_t          cfg;
  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [AW-1:0] rd_addr;

  rtvcr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtvcr_ctrl #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .status     (status)
  );

  rtvcr_dp #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .in_data    (in_tdata),
    .status     (status),
    .cell_value (out_tdata)
  );

endmodule

// File: tb/cell_level_checker.sv
// Word kinds on the input channel, shared by the checker and the stimulus.
package cell_cmd_pkg;
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_RENDER  = 1'b1;
  localparam int   TRACK_SLOTS = 32;
endpackage

// Watches the configuration, input and output channels. It keeps its own copy
// of the registers and the track table, predicts the level of every render
// word and compares each output word with the oldest prediction.
module cell_level_checker
  import rtvcr_pkg::*;
  import cell_cmd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     level_errors,
  output int                     levels_pending
);

  cfg_t                  regs;
  logic [AZ_W-1:0]       trk_az [TRACK_SLOTS];
  logic [RG_W-1:0]       trk_rg [TRACK_SLOTS];
  logic [OUT_DATA_W-1:0] expected_levels [$];
  int                    errors_seen = 0;

  // One minus a scaled gap, held at 0..1 in Q1.16.
  function automatic logic [63:0] clamp_level(input logic [63:0] amount);
    logic [63:0] drop;
    drop = amount >> 8;
    if (drop >= 64'd65536) begin
      return 64'd0;
    end
    return 64'd65536 - drop;
  endfunction

  // Saturated sum of the echoes of the first active tracks at one cell.
  function automatic logic [OUT_DATA_W-1:0] predict_cell_level(
    input logic [AZ_W-1:0] caz,
    input logic [RG_W-1:0] crg
  );
    logic [63:0] ratio;
    logic [63:0] gap;
    logic [63:0] x;
    logic [63:0] az_lvl;
    logic [63:0] rg_lvl;
    logic [63:0] norm;
    logic [63:0] add;
    logic [63:0] acc;
    longint      span_part;
    longint      gain_c;
    longint      corr;
    int          n;
    if (!regs.render_enable) begin
      return '0;
    end
    n = (regs.active_tracks > TRACK_SLOTS) ? TRACK_SLOTS : int'(regs.active_tracks);

    // The azimuth gap correction depends on the cell range only.
    ratio     = (64'(crg) * 64'(regs.inv_range_span)) >> 8;
    span_part = 64'sd65536 - longint'(ratio);
    gain_c    = longint'(regs.az_correction_gain);
    corr      = 64'sd16777216 - span_part * gain_c;

    acc = '0;
    for (int i = 0; i < n; i++) begin
      // A correction factor that is not positive leaves the azimuth level at one.
      if (corr <= 0) begin
        az_lvl = 64'd65536;
      end else begin
        gap    = (caz > trk_az[i]) ? 64'(caz) - 64'(trk_az[i]) : 64'(trk_az[i]) - 64'(caz);
        x      = (gap * 64'(corr)) >> 14;
        az_lvl = clamp_level(x * 64'(regs.az_gap_gain));
      end
      gap    = (crg > trk_rg[i]) ? 64'(crg) - 64'(trk_rg[i]) : 64'(trk_rg[i]) - 64'(crg);
      norm   = (gap * 64'(regs.inv_range_span)) >> 8;
      rg_lvl = clamp_level(norm * 64'(regs.range_gap_gain));
      add    = (64'd255 * 64'(regs.intensity_gain) * az_lvl * rg_lvl) >> 40;
      acc    = acc + add;
      if (acc > 64'd255) begin
        acc = 64'd255;
      end
    end
    return acc[OUT_DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.render_enable      = RST_RENDER_ENABLE;
      regs.active_tracks      = RST_ACTIVE_TRACKS;
      regs.az_gap_gain        = RST_AZ_GAP_GAIN;
      regs.az_correction_gain = RST_AZ_CORRECTION_GAIN;
      regs.range_gap_gain     = RST_RANGE_GAP_GAIN;
      regs.intensity_gain     = RST_INTENSITY_GAIN;
      regs.inv_range_span     = RST_INV_RANGE_SPAN;
      foreach (trk_az[i]) begin
        trk_az[i] = '0;
        trk_rg[i] = '0;
      end
      expected_levels.delete();
    end else begin
      // Register writes; an index past the list is dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RENDER_ENABLE:      regs.render_enable      = cfg_data[0];
          REG_ACTIVE_TRACKS:      regs.active_tracks      = cfg_data[5:0];
          REG_AZ_GAP_GAIN:        regs.az_gap_gain        = cfg_data;
          REG_AZ_CORRECTION_GAIN: regs.az_correction_gain = cfg_data;
          REG_RANGE_GAP_GAIN:     regs.range_gap_gain     = cfg_data;
          REG_INTENSITY_GAIN:     regs.intensity_gain     = cfg_data;
          REG_INV_RANGE_SPAN:     regs.inv_range_span     = cfg_data;
          default: ;
        endcase
      end

      // A load word updates the table, a render word queues its level.
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_LOAD) begin
          trk_az[in_tdata[SLOT_LSB +: SLOT_W]] = in_tdata[TAZ_LSB +: AZ_W];
          trk_rg[in_tdata[SLOT_LSB +: SLOT_W]] = in_tdata[TRG_LSB +: RG_W];
        end else begin
          expected_levels.push_back(
            predict_cell_level(in_tdata[CAZ_LSB +: AZ_W], in_tdata[CRG_LSB +: RG_W]));
        end
      end

      // Each output word is matched against the oldest queued level.
      if (out_tvalid && out_tready) begin
        if (expected_levels.size() == 0) begin
          errors_seen++;
          $display("%0t unexpected cell word: expected none, actual %0d", $time, out_tdata);
        end else if (out_tdata !== expected_levels[0]) begin
          errors_seen++;
          $display("%0t cell level mismatch: expected %0d, actual %0d",
                   $time, expected_levels[0], out_tdata);
          void'(expected_levels.pop_front());
        end else begin
          void'(expected_levels.pop_front());
        end
      end
    end
    levels_pending <= expected_levels.size();
    level_errors   <= errors_seen;
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import rtvcr_pkg::*;
  import cell_cmd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 230;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     level_errors;
  int                     levels_pending;

  bit                     feed_gaps;
  bit                     drain_stalls;
  logic [AZ_W-1:0]        placed_az [TRACK_SLOTS];
  logic [RG_W-1:0]        placed_rg [TRACK_SLOTS];

  radar_track_video_cell_renderer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cell_level_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .level_errors   (level_errors),
    .levels_pending (levels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop for a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("radar_track_video_cell_renderer: mismatch");
    $finish;
  end

  // Output side: ready drops in random bursts while stalls are on.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (drain_stalls && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic cfg_t make_cfg(input logic en, input logic [5:0] cnt,
                                    input logic [15:0] azg, input logic [15:0] azc,
                                    input logic [15:0] rgg, input logic [15:0] ig,
                                    input logic [15:0] inv);
    cfg_t v;
    v.render_enable      = en;
    v.active_tracks      = cnt;
    v.az_gap_gain        = azg;
    v.az_correction_gain = azc;
    v.range_gap_gain     = rgg;
    v.intensity_gain     = ig;
    v.inv_range_span     = inv;
    return v;
  endfunction

  // Half the time values around the nominal gain, else a full-range random value or an extreme.
  function automatic logic [15:0] pick_gain(input logic [15:0] nominal);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 65535));
      default: return nominal - (nominal >> 2) + 16'($urandom_range(0, nominal >> 1));
    endcase
  endfunction

  // One word on the input channel. The cell fields of a load word and the track fields of a render word are random.
  task automatic put_word(input logic cmd, input logic [SLOT_W-1:0] slot,
                          input logic [AZ_W-1:0] az, input logic [RG_W-1:0] rg);
    logic [IN_DATA_W-1:0] word;
    if (feed_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    word = '0;
    word[SLOT_LSB +: SLOT_W] = slot;
    word[TAZ_LSB +: AZ_W]    = AZ_W'($urandom_range(0, 32767));
    word[TRG_LSB +: RG_W]    = RG_W'($urandom_range(0, 65535));
    word[CAZ_LSB +: AZ_W]    = AZ_W'($urandom_range(0, 32767));
    word[CRG_LSB +: RG_W]    = RG_W'($urandom_range(0, 65535));
    if (cmd == CMD_LOAD) begin
      word[TAZ_LSB +: AZ_W] = az;
      word[TRG_LSB +: RG_W] = rg;
    end else begin
      word[CAZ_LSB +: AZ_W] = az;
      word[CRG_LSB +: RG_W] = rg;
    end
    in_tdata  <= word;
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_tready !== 1'b1);
    if (cmd == CMD_LOAD) begin
      placed_az[slot] = az;
      placed_rg[slot] = rg;
    end
  endtask

  // Holds the input back until every queued level has come out.
  task automatic wait_levels_drained();
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (levels_pending != 0);
  endtask

  // Writes every register back to back, optionally the unused index as well.
  task automatic program_regs(input cfg_t v, input bit poke_spare);
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  d;
    int                     last;
    wait_levels_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    last = poke_spare ? int'(REG_SPARE) : int'(REG_INV_RANGE_SPAN);
    for (int i = 0; i <= last; i++) begin
      idx = i[CFG_INDEX_W-1:0];
      d   = CFG_DATA_W'($urandom_range(0, 65535));
      case (idx)
        REG_RENDER_ENABLE:      d[0]   = v.render_enable;
        REG_ACTIVE_TRACKS:      d[5:0] = v.active_tracks;
        REG_AZ_GAP_GAIN:        d      = v.az_gap_gain;
        REG_AZ_CORRECTION_GAIN: d      = v.az_correction_gain;
        REG_RANGE_GAP_GAIN:     d      = v.range_gap_gain;
        REG_INTENSITY_GAIN:     d      = v.intensity_gain;
        REG_INV_RANGE_SPAN:     d      = v.inv_range_span;
        default: ;
      endcase
      cfg_index <= idx;
      cfg_data  <= d;
      cfg_valid <= 1'b1;
      do begin
        @(posedge clk);
      end while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [5:0]      cnt;
    logic [AZ_W-1:0] az;
    logic [RG_W-1:0] rg;
    int              s;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_LOAD;
    cfg_valid <= 1'b0;
    cfg_index <= REG_RENDER_ENABLE;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    feed_gaps    = 1'b1;
    drain_stalls = 1'b1;
    foreach (placed_az[i]) begin
      placed_az[i] = '0;
      placed_rg[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings over an empty table, then tracks at the field extremes.
    put_word(CMD_RENDER, '0, 15'd0, 16'd0);
    put_word(CMD_RENDER, '0, 15'h7FFF, 16'hFFFF);
    put_word(CMD_LOAD, 5'd31, 15'h7FFF, 16'hFFFF);
    put_word(CMD_LOAD, 5'd24, 15'd23039, 16'hFFFF);
    put_word(CMD_LOAD, 5'd1, 15'd100, 16'd1000);
    put_word(CMD_LOAD, 5'd2, 15'h7FFF, 16'd0);
    put_word(CMD_RENDER, '0, 15'd23039, 16'hFFFF);
    put_word(CMD_RENDER, '0, 15'd100, 16'd1000);
    put_word(CMD_RENDER, '0, 15'd110, 16'd1100);
    put_word(CMD_RENDER, '0, 15'h7FFF, 16'd0);
    put_word(CMD_RENDER, '0, 15'd0, 16'hFFFF);

    // Rendering switched off gives zero cells.
    program_regs(make_cfg(1'b0, 6'd32, 16'd512, 16'd256, 16'd25600, 16'hFFFF, 16'd655), 1'b1);
    put_word(CMD_RENDER, '0, 15'd100, 16'd1000);
    put_word(CMD_RENDER, '0, 15'd0, 16'd0);

    // Everything at its top value; a count past the table is cut to the table.
    program_regs(make_cfg(1'b1, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    put_word(CMD_RENDER, '0, 15'd100, 16'd1000);
    put_word(CMD_RENDER, '0, 15'h7FFF, 16'hFFFF);
    put_word(CMD_RENDER, '0, 15'd0, 16'd0);

    // Zero span inverse: the correction reaches exactly zero, goes negative, then is just positive.
    program_regs(make_cfg(1'b1, 6'd40, 16'd512, 16'd256, 16'd25600, 16'd256, 16'd0), 1'b0);
    put_word(CMD_RENDER, '0, 15'd300, 16'd5000);
    put_word(CMD_RENDER, '0, 15'h7FFF, 16'hFFFF);
    program_regs(make_cfg(1'b1, 6'd32, 16'd512, 16'hFFFF, 16'd25600, 16'd256, 16'd0), 1'b0);
    put_word(CMD_RENDER, '0, 15'd300, 16'd5000);
    program_regs(make_cfg(1'b1, 6'd32, 16'd512, 16'd255, 16'd25600, 16'd256, 16'd0), 1'b0);
    put_word(CMD_RENDER, '0, 15'd300, 16'd5000);

    // No active tracks, then all gains at zero, then only the intensity gain at its top.
    program_regs(make_cfg(1'b1, 6'd0, 16'd512, 16'd256, 16'd25600, 16'hFFFF, 16'd655), 1'b0);
    put_word(CMD_RENDER, '0, 15'd100, 16'd1000);
    program_regs(make_cfg(1'b1, 6'd32, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1), 1'b0);
    put_word(CMD_RENDER, '0, 15'd100, 16'd1000);
    program_regs(make_cfg(1'b1, 6'd32, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1), 1'b1);
    put_word(CMD_RENDER, '0, 15'h7FFF, 16'hFFFF);

    // Random phases: loads build track clusters, most renders land near a track.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: cnt = 6'd0;
        1: cnt = 6'd32;
        2: cnt = 6'($urandom_range(33, 63));
        default: cnt = 6'($urandom_range(1, 32));
      endcase
      program_regs(make_cfg($urandom_range(0, 9) != 0, cnt,
                            pick_gain(RST_AZ_GAP_GAIN), pick_gain(RST_AZ_CORRECTION_GAIN),
                            pick_gain(RST_RANGE_GAP_GAIN), pick_gain(RST_INTENSITY_GAIN),
                            pick_gain(RST_INV_RANGE_SPAN)),
                   1'($urandom_range(0, 1)));
      if (p == RANDOM_PHASES - 1) begin
        feed_gaps    = 1'b0;
        drain_stalls = 1'b0;
      end else begin
        feed_gaps    = $urandom_range(0, 3) != 0;
        drain_stalls = $urandom_range(0, 3) != 0;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        s = $urandom_range(0, TRACK_SLOTS - 1);
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 2) == 0) begin
            az = placed_az[s] + AZ_W'($urandom_range(0, 80)) - AZ_W'(40);
            rg = placed_rg[s] + RG_W'($urandom_range(0, 600)) - RG_W'(300);
          end else if ($urandom_range(0, 9) == 0) begin
            az = AZ_W'($urandom_range(23040, 32767));
            rg = RG_W'($urandom_range(0, 65535));
          end else begin
            az = AZ_W'($urandom_range(0, 23039));
            rg = RG_W'($urandom_range(0, 65535));
          end
          put_word(CMD_LOAD, SLOT_W'($urandom_range(0, TRACK_SLOTS - 1)), az, rg);
        end else begin
          if ($urandom_range(0, 99) < 65) begin
            az = placed_az[s] + AZ_W'($urandom_range(0, 80)) - AZ_W'(40);
            rg = placed_rg[s] + RG_W'($urandom_range(0, 600)) - RG_W'(300);
          end else begin
            az = AZ_W'($urandom_range(0, 32767));
            rg = RG_W'($urandom_range(0, 65535));
          end
          put_word(CMD_RENDER, '0, az, rg);
        end
        // Now and then the sender holds off until the output side is empty.
        if ($urandom_range(0, 99) == 0) begin
          wait_levels_drained();
        end
      end
    end

    wait_levels_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (level_errors == 0 && levels_pending == 0) begin
      $display("radar_track_video_cell_renderer: match");
    end else begin
      $display("radar_track_video_cell_renderer: mismatch");
    end
    $finish;
  end

endmodule
